/* rtl/core/sscw_pkg.sv */
`timescale 1ns / 1ps

package sscw_pkg;

   // absolute dimension limit of the descriptor layout
   localparam int DIMS_LIMIT       = 7;
   localparam int DEF_MAX_DIMS     = 7;
   localparam int DEF_OFFSET_BITS  = 48;
   localparam int FIELD_OFF_BITS   = 48;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_NEXT  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] length;
      logic [31:0] stride;
      logic [31:0] extent;
      logic [31:0] distance;
   } desc_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [2:0]  dim_index;
      logic [31:0] sec_start;
      logic [31:0] sec_length;
      logic [31:0] sec_stride;
      logic [31:0] sec_extent;
      logic [31:0] sec_distance;
      logic [2:0]  num_dims;
      logic [47:0] base_offset;
   } req_payload_type;

   typedef struct packed {
      logic        chunk_valid;
      logic [47:0] strided_offset;
      logic [47:0] packed_offset;
      logic [31:0] chunk_bytes;
      logic        last;
      logic        status;
   } rsp_payload_type;

   // deepest run of trailing full dims that merges into one chunk
   function automatic logic [2:0] find_merge(logic [2:0] n, logic [DIMS_LIMIT-1:0] full,
                                             logic [DIMS_LIMIT-1:0] unit);
      int   cd;
      logic stop;
      logic [2:0] res;
      cd   = int'(n) - 2;
      stop = 1'b0;
      res  = 3'd0;
      for (int i = DIMS_LIMIT - 2; i >= 0; i--) begin
         if (!stop && i <= int'(n) - 2) begin
            if (full[i+1] && unit[i]) begin
               cd = i;
            end else begin
               cd   = cd + 1;
               stop = 1'b1;
            end
         end
      end
      if (n <= 3'd1) begin
         res = 3'd0;
      end else if (!unit[n - 3'd1] || cd + 1 == int'(n)) begin
         res = n - 3'd1;
      end else begin
         res = 3'(cd);
      end
      return res;
   endfunction

endpackage

/* rtl/core/sscw_chan_if.sv */
`timescale 1ns / 1ps

interface sscw_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/sscw_ram.sv */
`timescale 1ns / 1ps

module sscw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read held between reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/sscw_mul.sv */
`timescale 1ns / 1ps

module sscw_mul (
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] product
);

   logic [63:0] product_ff;

   // shared 32x32 multiplier with registered product
   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= 64'(mul_a) * 64'(mul_b);
      end
   end

   assign product = product_ff;

endmodule

/* rtl/core/strided_section_chunk_walker_unit.sv */
`timescale 1ns / 1ps

// channel | dir | handshake           | payload
// req_bus | in  | valid/ready         | operation, descriptor, num_dims, base_offset
// rsp_bus | out | valid/ready         | chunk_valid, offsets, chunk_bytes, last, status
//
// a load or an unused operation goes straight to the response; a start checks each
// dim and picks the merge point; a next walks each dim up to it, then a merged chunk
// dim with saturated bytes, packs the offset and steps the odometer before the
// response; one shared 32x32 multiplier and the single port descriptor memory serialise
// these steps; synchronous reset clears the sequencer, walk state and odometer
// req_bus.ready is low from acceptance until the response beat is taken
module strided_section_chunk_walker_unit
   import sscw_pkg::*;
#(
   parameter int MAX_DIMS    = DEF_MAX_DIMS,
   parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
   input logic clock,
   input logic reset,
   sscw_chan_if.sink   req_bus,
   sscw_chan_if.source rsp_bus
);

   localparam int AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CW = $clog2(MAX_DIMS + 1);
   localparam logic [63:0] OFF_MASK = {64{1'b1}} >> (64 - OFFSET_BITS);

   typedef enum logic [15:0] {
      ST_IDLE      = 16'h0001,
      ST_SCAN_RD   = 16'h0002,
      ST_SCAN_CHK  = 16'h0004,
      ST_MERGE     = 16'h0008,
      ST_WALK_RD   = 16'h0010,
      ST_MUL_IDX   = 16'h0020,
      ST_ADD_IDX   = 16'h0040,
      ST_MUL_LO    = 16'h0080,
      ST_MUL_HI    = 16'h0100,
      ST_ACC_HI    = 16'h0200,
      ST_CHUNK_RD  = 16'h0400,
      ST_CHUNK_MS  = 16'h0800,
      ST_CHUNK_ML  = 16'h1000,
      ST_CHUNK_SAT = 16'h2000,
      ST_PACK      = 16'h4000,
      ST_RESP      = 16'h8000
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [2:0]            dims_ff, dims_in;
   logic [2:0]            merge_ff, merge_in;
   logic                  active_ff, active_in;
   logic [31:0]           odo_ff [MAX_DIMS];
   logic [31:0]           odo_in [MAX_DIMS];
   logic [MAX_DIMS-1:0]   wrap_ff, wrap_in;
   logic [MAX_DIMS-1:0]   full_ff, full_in;
   logic [MAX_DIMS-1:0]   unit_ff, unit_in;
   logic [MAX_DIMS-1:0]   zero_ff, zero_in;
   logic [OFFSET_BITS-1:0] acc_ff, acc_in;
   logic [OFFSET_BITS-1:0] packed_ff, packed_in;
   logic [63:0]           idx_ff, idx_in;
   logic [31:0]           bytes_ff, bytes_in;
   rsp_payload_type       rsp_ff, rsp_in;

   req_payload_type req;
   desc_type        desc;
   desc_type        wr_desc;
   logic            ram_wr;
   logic            ram_rd;
   logic [AW-1:0]   cidx;
   logic            mul_en;
   logic [31:0]     mul_a, mul_b;
   logic [63:0]     prod;
   logic            accept;
   logic            empty;
   logic [2:0]      n_clamp;
   logic [DIMS_LIMIT-1:0] full_x, unit_x;

   assign req     = req_bus.payload;
   assign accept  = req_bus.valid && req_bus.ready;
   assign cidx    = cnt_ff[AW-1:0];
   assign full_x  = DIMS_LIMIT'(full_ff);
   assign unit_x  = DIMS_LIMIT'(unit_ff);

   assign req_bus.ready   = (state_ff == ST_IDLE);
   assign rsp_bus.valid   = (state_ff == ST_RESP);
   assign rsp_bus.payload = rsp_ff;

   // descriptor store
   assign wr_desc = '{start: req.sec_start, length: req.sec_length, stride: req.sec_stride,
                      extent: req.sec_extent, distance: req.sec_distance};
   assign ram_wr  = accept && (op_type'(req.operation) == OP_LOAD)
                    && (32'(req.dim_index) < 32'(MAX_DIMS));
   assign ram_rd  = (state_ff == ST_SCAN_RD) || (state_ff == ST_WALK_RD)
                    || (state_ff == ST_CHUNK_RD);

   sscw_ram #(
      .WIDTH ($bits(desc_type)),
      .DEPTH (MAX_DIMS)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (AW'(req.dim_index)),
      .wr_data (wr_desc),
      .rd_en   (ram_rd),
      .rd_addr (cidx),
      .rd_data (desc)
   );

   // operand select for the shared multiplier
   always_comb begin
      mul_en = 1'b1;
      mul_a  = 32'd0;
      mul_b  = 32'd0;
      unique case (state_ff)
         ST_MUL_IDX: begin
            mul_a = odo_ff[cidx];
            mul_b = desc.stride;
         end
         ST_MUL_LO: begin
            mul_a = idx_ff[31:0];
            mul_b = desc.distance;
         end
         ST_MUL_HI: begin
            mul_a = idx_ff[63:32];
            mul_b = desc.distance;
         end
         ST_CHUNK_MS: begin
            mul_a = desc.start;
            mul_b = desc.distance;
         end
         ST_CHUNK_ML: begin
            mul_a = desc.length;
            mul_b = desc.distance;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   sscw_mul u_mul (
      .clock   (clock),
      .enable  (mul_en),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (prod)
   );

   // dim count clamp for a start beat
   always_comb begin
      n_clamp = req.num_dims;
      if (n_clamp == 3'd0) begin
         n_clamp = 3'd1;
      end
      if (32'(n_clamp) > 32'(MAX_DIMS)) begin
         n_clamp = 3'(MAX_DIMS);
      end
   end

   // any empty dim among those in use
   always_comb begin
      empty = 1'b0;
      for (int d = 0; d < MAX_DIMS; d++) begin
         if (d < int'(dims_ff) && zero_ff[d]) begin
            empty = 1'b1;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      dims_in   = dims_ff;
      merge_in  = merge_ff;
      active_in = active_ff;
      odo_in    = odo_ff;
      wrap_in   = wrap_ff;
      full_in   = full_ff;
      unit_in   = unit_ff;
      zero_in   = zero_ff;
      acc_in    = acc_ff;
      packed_in = packed_ff;
      idx_in    = idx_ff;
      bytes_in  = bytes_ff;
      rsp_in    = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in   = '0;
               cnt_in   = '0;
               state_in = ST_RESP;
               unique case (op_type'(req.operation))
                  OP_START: begin
                     dims_in   = n_clamp;
                     packed_in = OFFSET_BITS'(req.base_offset);
                     active_in = 1'b0;
                     for (int d = 0; d < MAX_DIMS; d++) begin
                        odo_in[d] = 32'd0;
                     end
                     state_in = ST_SCAN_RD;
                  end
                  OP_NEXT: begin
                     if (active_ff) begin
                        acc_in   = '0;
                        state_in = ST_WALK_RD;
                     end else begin
                        rsp_in.status = 1'b1;
                     end
                  end
                  OP_LOAD, OP_NONE: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            full_in[cidx] = (desc.start == 32'd0) && (desc.length == desc.extent)
                            && (desc.stride == 32'd1);
            unit_in[cidx] = (desc.stride == 32'd1);
            zero_in[cidx] = (desc.length == 32'd0);
            if (4'(cnt_ff) + 4'd1 < 4'(dims_ff)) begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            merge_in    = find_merge(dims_ff, full_x, unit_x);
            active_in   = !empty;
            rsp_in.last = empty;
            state_in    = ST_RESP;
         end
         ST_WALK_RD: begin
            state_in = ST_MUL_IDX;
         end
         ST_MUL_IDX: begin
            wrap_in[cidx] = (33'(odo_ff[cidx]) + 33'd1) >= 33'(desc.length);
            state_in      = ST_ADD_IDX;
         end
         ST_ADD_IDX: begin
            idx_in   = (prod + 64'(desc.start)) & OFF_MASK;
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            acc_in   = acc_ff + OFFSET_BITS'(prod);
            state_in = ST_ACC_HI;
         end
         ST_ACC_HI: begin
            acc_in = acc_ff + OFFSET_BITS'({prod, 32'd0});
            cnt_in = cnt_ff + CW'(1);
            if (4'(cnt_ff) < 4'(merge_ff)) begin
               state_in = ST_WALK_RD;
            end else if (4'(cnt_ff) + 4'd1 < 4'(dims_ff)) begin
               state_in = ST_CHUNK_RD;
            end else begin
               bytes_in = desc.distance;
               state_in = ST_PACK;
            end
         end
         ST_CHUNK_RD: begin
            state_in = ST_CHUNK_MS;
         end
         ST_CHUNK_MS: begin
            state_in = ST_CHUNK_ML;
         end
         ST_CHUNK_ML: begin
            acc_in   = acc_ff + OFFSET_BITS'(prod);
            state_in = ST_CHUNK_SAT;
         end
         ST_CHUNK_SAT: begin
            bytes_in = (prod[63:32] != 32'd0) ? 32'hFFFF_FFFF : prod[31:0];
            state_in = ST_PACK;
         end
         ST_PACK: begin
            rsp_in.chunk_valid    = 1'b1;
            rsp_in.strided_offset = FIELD_OFF_BITS'(acc_ff);
            rsp_in.packed_offset  = FIELD_OFF_BITS'(packed_ff);
            rsp_in.chunk_bytes    = bytes_ff;
            packed_in             = packed_ff + OFFSET_BITS'(bytes_ff);
            cnt_in                = CW'(merge_ff);
            state_in              = ST_PACK;
         end
         ST_RESP: begin
            if (rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // odometer advance runs in the pack state once the payload is latched
   logic adv_busy_ff, adv_busy_in;

   always_comb begin
      adv_busy_in = adv_busy_ff;
      if (state_ff != ST_PACK) begin
         adv_busy_in = 1'b0;
      end else if (!adv_busy_ff) begin
         adv_busy_in = 1'b1;
      end
   end

   logic            adv_step;
   logic            adv_done;
   logic            adv_carry;
   logic [31:0]     odo_next;

   assign adv_step  = (state_ff == ST_PACK) && adv_busy_ff;
   assign odo_next  = odo_ff[cidx] + 32'd1;
   assign adv_carry = wrap_ff[cidx] && (cnt_ff == '0);
   assign adv_done  = adv_step && (!wrap_ff[cidx] || cnt_ff == '0);

   state_type           state_fin;
   logic [CW-1:0]       cnt_fin;
   logic                active_fin;
   logic [31:0]         odo_fin [MAX_DIMS];
   rsp_payload_type     rsp_fin;
   logic [OFFSET_BITS-1:0] packed_fin;

   always_comb begin
      state_fin  = state_in;
      cnt_fin    = cnt_in;
      active_fin = active_in;
      odo_fin    = odo_in;
      rsp_fin    = rsp_in;
      packed_fin = packed_in;
      if (state_ff == ST_PACK) begin
         if (!adv_busy_ff) begin
            // first cycle latches the payload and moves the packed position
            state_fin = ST_PACK;
         end else begin
            rsp_fin    = rsp_ff;
            packed_fin = packed_ff;
            cnt_fin    = cnt_ff;
            if (wrap_ff[cidx]) begin
               odo_fin[cidx] = 32'd0;
            end else begin
               odo_fin[cidx] = odo_next;
            end
            if (adv_done) begin
               rsp_fin.last = adv_carry;
               if (adv_carry) begin
                  active_fin = 1'b0;
               end
               state_fin = ST_RESP;
            end else begin
               cnt_fin   = cnt_ff - CW'(1);
               state_fin = ST_PACK;
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         dims_ff     <= 3'd1;
         merge_ff    <= 3'd0;
         active_ff   <= 1'b0;
         adv_busy_ff <= 1'b0;
         packed_ff   <= '0;
         for (int d = 0; d < MAX_DIMS; d++) begin
            odo_ff[d] <= 32'd0;
         end
      end else begin
         state_ff    <= state_fin;
         cnt_ff      <= cnt_fin;
         dims_ff     <= dims_in;
         merge_ff    <= merge_in;
         active_ff   <= active_fin;
         adv_busy_ff <= adv_busy_in;
         packed_ff   <= packed_fin;
         odo_ff      <= odo_fin;
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      wrap_ff  <= wrap_in;
      full_ff  <= full_in;
      unit_ff  <= unit_in;
      zero_ff  <= zero_in;
      acc_ff   <= acc_in;
      idx_ff   <= idx_in;
      bytes_ff <= bytes_in;
      rsp_ff   <= rsp_fin;
   end

`ifndef SYNTHESIS
   a_ready_excl: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !rsp_bus.valid)
      else $error("input ready while a response beat is pending");

   a_status_no_chunk: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.payload.status) |-> !rsp_bus.payload.chunk_valid)
      else $error("error status on a chunk beat");

   a_idle_next: assert property (@(posedge clock) disable iff (reset)
      (accept && op_type'(req.operation) == OP_NEXT && !active_ff)
      |=> (rsp_bus.valid && rsp_bus.payload.status))
      else $error("next without walk not flagged");

   a_last_ends_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.payload.chunk_valid && rsp_bus.payload.last) |-> !active_ff)
      else $error("walk still active after final chunk");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
   import sscw_pkg::*;

   localparam int NDIM = 7;
   localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sscw_chan_if #(.payload_type(req_payload_type)) req_bus ();
   sscw_chan_if #(.payload_type(rsp_payload_type)) rsp_bus ();

   strided_section_chunk_walker_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   int mismatch_count = 0;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("error at %0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // walker model and queue of expected response beats
   class chunk_scoreboard;
      desc_type          dims[NDIM];
      logic [31:0]       digit[NDIM];
      logic [47:0]       pack_pos;
      int                walk_dim;
      int                used;
      bit                active;
      rsp_payload_type   pending[$];

      function void clear();
         foreach (digit[d]) digit[d] = '0;
         pack_pos = '0;
         walk_dim = 0;
         used     = 1;
         active   = 1'b0;
         pending.delete();
      endfunction

      function bit is_full(int d);
         return dims[d].start == 0 && dims[d].length == dims[d].extent && dims[d].stride == 1;
      endfunction

      function int merge_point(int n);
         int cd;
         if (n <= 1) return 0;
         cd = n - 2;
         for (int i = n - 2; i >= 0; i--) begin
            if (is_full(i + 1) && dims[i].stride == 1) begin
               cd = i;
            end else begin
               cd++;
               break;
            end
         end
         if (dims[n-1].stride != 1 || cd + 1 == n) return n - 1;
         return cd;
      endfunction

      function void note_request(req_payload_type rq);
         rsp_payload_type r;
         logic [63:0] bytes;
         logic [47:0] acc;
         logic [63:0] idx;
         bit carry;
         int n;
         r = '0;
         case (op_type'(rq.operation))
            OP_LOAD: begin
               if (rq.dim_index < NDIM)
                  dims[rq.dim_index] = '{rq.sec_start, rq.sec_length, rq.sec_stride,
                                         rq.sec_extent, rq.sec_distance};
            end
            OP_START: begin
               n = rq.num_dims;
               if (n == 0) n = 1;
               used     = n;
               walk_dim = merge_point(n);
               pack_pos = rq.base_offset;
               foreach (digit[d]) digit[d] = '0;
               active = 1'b1;
               for (int d = 0; d < n; d++) if (dims[d].length == 0) active = 1'b0;
               r.last = !active;
            end
            OP_NEXT: begin
               if (!active) begin
                  r.status = 1'b1;
               end else begin
                  acc = '0;
                  for (int d = 0; d <= walk_dim; d++) begin
                     idx = 64'(digit[d]) * dims[d].stride + dims[d].start;
                     acc = acc + 48'(idx * dims[d].distance);
                  end
                  if (walk_dim + 1 < used) begin
                     acc   = acc + 48'(64'(dims[walk_dim+1].start) * dims[walk_dim+1].distance);
                     bytes = 64'(dims[walk_dim+1].length) * dims[walk_dim+1].distance;
                     if (bytes > 64'hFFFF_FFFF) bytes = 64'hFFFF_FFFF;
                  end else begin
                     bytes = dims[used-1].distance;
                  end
                  r.chunk_valid    = 1'b1;
                  r.strided_offset = acc;
                  r.packed_offset  = pack_pos;
                  r.chunk_bytes    = bytes[31:0];
                  pack_pos = pack_pos + 48'(bytes);
                  carry = 1'b1;
                  for (int k = walk_dim; k >= 0 && carry; k--) begin
                     if (64'(digit[k]) + 1 >= dims[k].length) begin
                        digit[k] = '0;
                     end else begin
                        digit[k] = digit[k] + 1;
                        carry = 1'b0;
                     end
                  end
                  if (carry) begin
                     active = 1'b0;
                     r.last = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         pending.push_back(r);
      endfunction

      task check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (pending.size() == 0) begin
            report("unexpected beat", 64'(got), 0);
            return;
         end
         want = pending.pop_front();
         if (got.chunk_valid !== want.chunk_valid)
            report("chunk_valid", got.chunk_valid, want.chunk_valid);
         if (got.strided_offset !== want.strided_offset)
            report("strided_offset", got.strided_offset, want.strided_offset);
         if (got.packed_offset !== want.packed_offset)
            report("packed_offset", got.packed_offset, want.packed_offset);
         if (got.chunk_bytes !== want.chunk_bytes)
            report("chunk_bytes", got.chunk_bytes, want.chunk_bytes);
         if (got.last !== want.last) report("last", got.last, want.last);
         if (got.status !== want.status) report("status", got.status, want.status);
      endtask
   endclass

   chunk_scoreboard board = new();

   bit quiet_phase = 1'b0;
   bit hold_off    = 1'b0;
   int idle_cycles = 0;
   req_payload_type item_q[$];

   // monitor both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) board.note_request(req_bus.payload);
         if (rsp_bus.valid && rsp_bus.ready) board.check_response(rsp_bus.payload);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("strided_section_chunk_walker_unit: mismatch");
            $finish;
         end
      end
   end

   // response side ready with random stall bursts
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_bus.ready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   task automatic send_beat(input req_payload_type p);
      int gap;
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= p;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   function automatic req_payload_type load_item(int d, logic [31:0] st, logic [31:0] ln,
                                                 logic [31:0] sd, logic [31:0] ex,
                                                 logic [31:0] ds);
      req_payload_type p;
      p = '0;
      p.operation    = OP_LOAD;
      p.dim_index    = 3'(d);
      p.sec_start    = st;
      p.sec_length   = ln;
      p.sec_stride   = sd;
      p.sec_extent   = ex;
      p.sec_distance = ds;
      p.num_dims     = 3'($urandom);
      p.base_offset  = 48'({$urandom, $urandom});
      return p;
   endfunction

   function automatic req_payload_type ctl_item(op_type op, logic [2:0] n, logic [47:0] base);
      req_payload_type p;
      p = '0;
      p.operation    = op;
      p.dim_index    = 3'($urandom);
      p.sec_start    = $urandom;
      p.sec_length   = $urandom;
      p.sec_stride   = $urandom;
      p.sec_extent   = $urandom;
      p.sec_distance = $urandom;
      p.num_dims     = n;
      p.base_offset  = base;
      return p;
   endfunction

   // random walk: small lengths, many merge shapes, some noise
   task automatic queue_walk();
      int n, nexts;
      logic [31:0] ln, sd, st;
      n = $urandom_range(1, 7);
      for (int d = 0; d < NDIM; d++) begin
         ln = $urandom_range(0, 20) == 0 ? 0 : $urandom_range(1, 3);
         if ($urandom_range(0, 2) != 0) begin
            item_q.push_back(load_item(d, 0, ln, 1, ln, $urandom_range(1, 64)));
         end else begin
            sd = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4);
            st = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3);
            item_q.push_back(load_item(d, st, ln, sd,
                                       $urandom_range(0, 1) ? ln : $urandom, $urandom));
         end
      end
      item_q.push_back(ctl_item(OP_START, 3'(n), 48'({$urandom, $urandom})));
      nexts = $urandom_range(1, 30);
      for (int i = 0; i < nexts; i++) begin
         case ($urandom_range(0, 19))
            0: item_q.push_back(load_item($urandom_range(0, 7), 0, $urandom_range(1, 3),
                                          1, $urandom_range(1, 3), $urandom));
            1: item_q.push_back(ctl_item(OP_NONE, 3'($urandom), 48'({$urandom, $urandom})));
            2: item_q.push_back(ctl_item(OP_START, 3'($urandom), 48'({$urandom, $urandom})));
            default: item_q.push_back(ctl_item(OP_NEXT, 3'($urandom),
                                               48'({$urandom, $urandom})));
         endcase
      end
   endtask

   initial begin
      int sent;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      board.clear();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: extremes, every operation, empty walk, merge, saturation
      item_q.push_back(ctl_item(OP_NEXT, 0, 0));
      for (int d = 0; d < NDIM; d++)
         item_q.push_back(load_item(d, 32'hFFFF_FFFF, 2, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF));
      item_q.push_back(load_item(7, 1, 1, 1, 1, 1));
      item_q.push_back(ctl_item(OP_START, 0, M48));
      item_q.push_back(ctl_item(OP_NEXT, 0, 0));
      item_q.push_back(ctl_item(OP_NEXT, 0, 0));
      item_q.push_back(ctl_item(OP_NEXT, 0, 0));
      item_q.push_back(load_item(1, 0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      item_q.push_back(load_item(0, 0, 2, 1, 2, 8));
      item_q.push_back(ctl_item(OP_START, 2, 48'h1234));
      item_q.push_back(ctl_item(OP_NEXT, 0, 0));
      item_q.push_back(load_item(0, 0, 1, 1, 1, 8));
      item_q.push_back(ctl_item(OP_NEXT, 0, 0));
      item_q.push_back(load_item(3, 0, 0, 1, 0, 4));
      item_q.push_back(ctl_item(OP_START, 7, 0));
      item_q.push_back(ctl_item(OP_NONE, 7, M48));
      item_q.push_back(ctl_item(OP_NEXT, 7, 0));
      item_q.push_back(ctl_item(OP_START, 1, 0));
      item_q.push_back(ctl_item(OP_START, 3, 5));
      while (item_q.size() != 0) send_beat(item_q.pop_front());
      wait_drained();

      // long receiver stall while requests keep coming
      hold_off = 1'b1;
      queue_walk();
      while (item_q.size() != 0) send_beat(item_q.pop_front());
      wait_drained();

      sent = 0;
      while (sent < 1500) begin
         if (sent > 1200) quiet_phase = 1'b1;
         queue_walk();
         while (item_q.size() != 0) begin
            send_beat(item_q.pop_front());
            sent++;
         end
         if ($urandom_range(0, 9) == 0) wait_drained();
      end
      wait_drained();
      repeat (200) @(negedge clock);

      if (mismatch_count == 0 && board.pending.size() == 0)
         $display("strided_section_chunk_walker_unit: match");
      else
         $display("strided_section_chunk_walker_unit: mismatch");
      $finish;
   end
endmodule

/* filelist.f */
rtl/core/sscw_pkg.sv
rtl/core/sscw_chan_if.sv
rtl/core/sscw_ram.sv
rtl/core/sscw_mul.sv
rtl/core/strided_section_chunk_walker_unit.sv
test/tb.sv
